@@ design/pis_pkg.sv @@
`default_nettype none
package pis_pkg;

  // Field widths of the stream items
  localparam int InW      = 28;
  localparam int VW       = 25;
  localparam int BW       = 29;
  localparam int InDataW  = 248;
  localparam int OutDataW = 112;
  localparam int OutUserW = 2;

  // Internal exact-integer widths
  localparam int BbW   = 58;
  localparam int BvW   = 55;
  localparam int QaW   = 51;
  localparam int SpdW  = 24;
  localparam int Spd2W = 48;
  localparam int ProdW = 108;
  localparam int DiscW = 112;
  localparam int RemW  = 58;

  // Iteration counts
  localparam int SqSteps  = 56;
  localparam int DivSteps = 41;
  localparam int AimSteps = 26;
  localparam int AimRemW  = 41;

  // Front-to-back queue
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;

  localparam logic [SpdW-1:0]     SpdReset  = 24'd256000;
  localparam logic [Spd2W-1:0]    Spd2Reset = 48'(SpdReset) * 48'(SpdReset);
  localparam logic [DivSteps-1:0] TimeCap   = 41'd1 << 40;
  localparam logic [DivSteps-1:0] TimeMax   = 41'h0_7FFF_FFFF;
  localparam logic [31:0]         NoTime    = 32'hFFFF_0000;
  localparam logic signed [27:0]  AimMax    = 28'sd16777215;
  localparam logic signed [27:0]  AimMin    = -28'sd16777216;

  // One classified request: offsets, velocity and the dot products
  typedef struct packed {
    logic [2:0][BW-1:0]    b;
    logic [2:0][VW-1:0]    v;
    logic [BbW-1:0]        bb;
    logic signed [BvW-1:0] bv;
    logic signed [QaW-1:0] qa;
  } item_t;

  typedef struct packed {
    item_t            it;
    logic [2:0][53:0] pb;
    logic [3:0][53:0] pq;
  } pp_t;

  typedef struct packed {
    item_t            it;
    logic [ProdW-1:0] bv2;
    logic [ProdW-1:0] qbb;
  } sum_t;

  typedef struct packed {
    item_t              it;
    logic               ok;
    logic               lin;
    logic [DiscW-1:0]   disc;
    logic [RemW-1:0]    rem;
    logic [SqSteps-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DivSteps-1:0] n;
    logic [RemW-1:0]     d;
    logic [RemW-1:0]     rem;
    logic [DivSteps-1:0] q;
    logic                big;
    logic                neg;
  } tlane_t;

  typedef struct packed {
    item_t  it;
    logic   ok;
    logic   lin;
    tlane_t la;
    tlane_t lb;
  } dv_t;

  typedef struct packed {
    item_t               it;
    logic                ok;
    logic [DivSteps-1:0] t;
  } st_t;

  typedef struct packed {
    logic [AimSteps-1:0] n;
    logic [AimRemW-1:0]  rem;
    logic [AimSteps-1:0] q;
    logic                big;
    logic                neg;
  } alane_t;

  typedef struct packed {
    item_t               it;
    logic                ok;
    logic [DivSteps-1:0] t;
    alane_t [2:0]        ln;
  } am_t;

endpackage
`default_nettype wire

@@ design/projectile_intercept_solver_core.sv @@
// Projectile intercept solver. Each request carries a gun origin, a target
// position (signed Q20.8) and a target velocity (signed Q17.8); the result
// gives the aim velocity B/t + V (signed Q17.8), the earliest positive
// intercept time t (signed Q16.16), a found flag and a saturated flag. With
// no solution the aim is zero, the time is -1.0 and both flags are low. The
// projectile speed (unsigned Q16.8, reset 1000.0) is written on the cfg
// channel, which is always ready; write it only while no request is in
// flight. Throughput is one request per clock when the output is not held.
// A request passes the front end that forms B.B, B.V and V.V, the 4-deep
// queue, and the solver with the 56-step square root of the discriminant,
// the two 41-step time dividers and the 26-step aim dividers. A stall on
// the result side holds the whole solver; the queue lets the front end
// keep taking requests until it is full.
`default_nettype none
module projectile_intercept_solver_core
  import pis_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [SpdW-1:0]     cfg_data_i,       // projectile_speed
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // gun_x, gun_y, gun_z, target_x, target_y, target_z,
  // target_vx, target_vy, target_vz, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // aim_vx, aim_vy, aim_vz, hit_time, zero pad
  output logic [OutUserW-1:0] m_axis_tuser_o    // found, saturated
);

  // Hold the squared speed; the front end only ever needs Q^2
  logic [Spd2W-1:0] spd2_q;

  logic  f_valid, f_ready;
  item_t f_item;
  logic  b_valid, b_ready;
  item_t b_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd2_q <= Spd2Reset;
    end else if (cfg_valid_i) begin
      spd2_q <= Spd2W'(cfg_data_i) * Spd2W'(cfg_data_i);
    end
  end

  // Front end: offsets and dot products
  pis_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .spd2_i      (spd2_q),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_item_o  (f_item)
  );

  // Decouple the front end from solver stalls
  pis_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_item_i   (f_item),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_item_o  (b_item)
  );

  // Solver: discriminant, root, divisions, aim and clamping
  pis_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_valid),
    .in_ready_o  (b_ready),
    .in_item_i   (b_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

`ifndef NO_ASSERTIONS
  a_none_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0]
      |-> m_axis_tdata_o[106:75] == NoTime && m_axis_tdata_o[74:0] == '0)
    else $error("result without solution carries aim or time");

  a_found_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0]
      |-> !m_axis_tdata_o[106] && m_axis_tdata_o[106:75] != '0)
    else $error("found result with non-positive time");

  a_sat_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tuser_o[0])
    else $error("saturated flag without solution");
`endif

endmodule
`default_nettype wire

@@ design/pis_front.sv @@
`default_nettype none
module pis_front
  import pis_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [InDataW-1:0] in_data_i,
  input  logic [Spd2W-1:0]   spd2_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output item_t              out_item_o
);

  logic                 fen;
  logic [2:0]           valid_q;
  logic [2:0][BW-1:0]   b_d, b_q, b2_q;
  logic [2:0][VW-1:0]   v_d, v1_q, v2_q;
  logic [2:0][56:0]     bb_d, bb_q;
  logic [2:0][53:0]     bv_d, bv_q;
  logic [2:0][48:0]     vv_d, vv_q;
  logic signed [57:0]   pbb [3];
  logic signed [53:0]   pbv [3];
  logic signed [49:0]   pvv [3];
  logic [49:0]          vv_sum;
  item_t                item_d, item_q;

  // advance unless the last stage holds a request the queue will not take
  assign fen         = !valid_q[2] || out_ready_i;
  assign in_ready_o  = fen;
  assign out_valid_o = valid_q[2];
  assign out_item_o  = item_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      b_d[k] = {in_data_i[(3+k)*InW+InW-1], in_data_i[(3+k)*InW +: InW]}
             - {in_data_i[k*InW+InW-1], in_data_i[k*InW +: InW]};
      v_d[k] = in_data_i[6*InW + k*VW +: VW];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pbb[k]  = $signed(b_q[k]) * $signed(b_q[k]);
      pbv[k]  = $signed(b_q[k]) * $signed(v1_q[k]);
      pvv[k]  = $signed(v1_q[k]) * $signed(v1_q[k]);
      bb_d[k] = pbb[k][56:0];
      bv_d[k] = pbv[k];
      vv_d[k] = pvv[k][48:0];
    end
  end

  always_comb begin
    vv_sum      = 50'(vv_q[0]) + 50'(vv_q[1]) + 50'(vv_q[2]);
    item_d.b    = b2_q;
    item_d.v    = v2_q;
    item_d.bb   = 58'(bb_q[0]) + 58'(bb_q[1]) + 58'(bb_q[2]);
    item_d.bv   = 55'($signed(bv_q[0])) + 55'($signed(bv_q[1])) + 55'($signed(bv_q[2]));
    item_d.qa   = $signed({1'b0, vv_sum}) - $signed({3'b000, spd2_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (fen) begin
      valid_q <= {valid_q[1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (fen) begin
      b_q    <= b_d;
      v1_q   <= v_d;
      b2_q   <= b_q;
      v2_q   <= v1_q;
      bb_q   <= bb_d;
      bv_q   <= bv_d;
      vv_q   <= vv_d;
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

@@ design/pis_queue.sv @@
`default_nettype none
module pis_queue
  import pis_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output item_t out_item_o
);

  item_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic             push, pop;

  assign in_ready_o  = cnt_q != (QPtrW+1)'(QDepth);
  assign out_valid_o = cnt_q != '0;
  assign out_item_o  = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item_i;
  end

endmodule
`default_nettype wire

@@ design/pis_back.sv @@
`default_nettype none
module pis_back
  import pis_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  item_t               in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic [OutUserW-1:0] out_user_o
);

  // One restoring step of the integer square root
  function automatic sq_t sq_step(sq_t s);
    sq_t         r;
    logic [59:0] cur;
    logic [57:0] trial;
    r      = s;
    cur    = {s.rem, s.disc[DiscW-1 -: 2]};
    trial  = {s.root, 2'b01};
    r.disc = {s.disc[DiscW-3:0], 2'b00};
    if (cur >= {2'b00, trial}) begin
      r.rem  = 58'(cur - {2'b00, trial});
      r.root = {s.root[SqSteps-2:0], 1'b1};
    end else begin
      r.rem  = cur[57:0];
      r.root = {s.root[SqSteps-2:0], 1'b0};
    end
    return r;
  endfunction

  // Set up num * 2^16 / den; big marks a quotient of 2^41 or more
  function automatic tlane_t tdv_init(logic [RemW-1:0] num, logic [RemW-1:0] den,
                                      logic neg);
    tlane_t      r;
    logic [73:0] nn;
    logic [32:0] hi;
    nn    = {num, 16'h0000};
    hi    = nn[73:41];
    r.n   = nn[40:0];
    r.d   = den;
    r.big = {25'b0, hi} >= den;
    r.rem = r.big ? '0 : {25'b0, hi};
    r.q   = '0;
    r.neg = neg;
    return r;
  endfunction

  function automatic tlane_t tdv_step(tlane_t l);
    tlane_t      r;
    logic [58:0] cur;
    r   = l;
    cur = {l.rem, l.n[DivSteps-1]};
    r.n = {l.n[DivSteps-2:0], 1'b0};
    if (cur >= {1'b0, l.d}) begin
      r.rem = 58'(cur - {1'b0, l.d});
      r.q   = {l.q[DivSteps-2:0], 1'b1};
    end else begin
      r.rem = cur[57:0];
      r.q   = {l.q[DivSteps-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t dv_step(dv_t x);
    dv_t r;
    r    = x;
    r.la = tdv_step(x.la);
    r.lb = tdv_step(x.lb);
    return r;
  endfunction

  // Clamp the magnitude at the time cap and apply the sign
  function automatic logic signed [41:0] tclamp(tlane_t l);
    logic [DivSteps-1:0] m;
    m = (l.big || l.q > TimeCap) ? TimeCap : l.q;
    return l.neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic alane_t aim_step(alane_t l, logic [DivSteps-1:0] t);
    alane_t      r;
    logic [41:0] cur;
    r   = l;
    cur = {l.rem, l.n[AimSteps-1]};
    r.n = {l.n[AimSteps-2:0], 1'b0};
    if (cur >= {1'b0, t}) begin
      r.rem = 41'(cur - {1'b0, t});
      r.q   = {l.q[AimSteps-2:0], 1'b1};
    end else begin
      r.rem = cur[40:0];
      r.q   = {l.q[AimSteps-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic am_t am_step(am_t x);
    am_t r;
    r = x;
    for (int k = 0; k < 3; k++) r.ln[k] = aim_step(x.ln[k], x.t);
    return r;
  endfunction

  logic adv;
  logic p_valid_q, s_valid_q, d_valid_q, t_valid_q, sel_valid_q, as_valid_q, out_valid_q;
  logic [SqSteps-1:0]  sq_valid_q;
  logic [DivSteps-1:0] dv_valid_q;
  logic [AimSteps-1:0] am_valid_q;

  pp_t  p_d, p_q;
  sum_t s_d, s_q;
  sq_t  d_d, d_q;
  sq_t  sq_q [SqSteps];
  dv_t  t_d, t_q;
  dv_t  dv_q [DivSteps];
  st_t  sel_d, sel_q;
  am_t  as_d, as_q;
  am_t  am_q [AimSteps];
  logic [OutDataW-1:0] out_data_d, out_data_q;
  logic [OutUserW-1:0] out_user_d, out_user_q;

  // whole pipeline holds while a finished result waits at the output
  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  // partial products of (B.V)^2 and |qa| * B.B
  logic [53:0] bvm;
  logic [49:0] qam;
  always_comb begin
    bvm      = in_item_i.bv[BvW-1] ? 54'(-in_item_i.bv) : in_item_i.bv[53:0];
    qam      = in_item_i.qa[QaW-1] ? 50'(-in_item_i.qa) : in_item_i.qa[49:0];
    p_d.it   = in_item_i;
    p_d.pb[0] = bvm[26:0]  * bvm[26:0];
    p_d.pb[1] = bvm[26:0]  * bvm[53:27];
    p_d.pb[2] = bvm[53:27] * bvm[53:27];
    p_d.pq[0] = qam[24:0]  * in_item_i.bb[28:0];
    p_d.pq[1] = qam[24:0]  * in_item_i.bb[57:29];
    p_d.pq[2] = qam[49:25] * in_item_i.bb[28:0];
    p_d.pq[3] = qam[49:25] * in_item_i.bb[57:29];
  end

  always_comb begin
    s_d.it  = p_q.it;
    s_d.bv2 = ProdW'(p_q.pb[0]) + (ProdW'(p_q.pb[1]) << 28) + (ProdW'(p_q.pb[2]) << 54);
    s_d.qbb = ProdW'(p_q.pq[0]) + (ProdW'(p_q.pq[1]) << 29)
            + (ProdW'(p_q.pq[2]) << 25) + (ProdW'(p_q.pq[3]) << 54);
  end

  // discriminant and the linear case
  always_comb begin
    d_d.it   = s_q.it;
    d_d.lin  = s_q.it.qa == '0;
    d_d.rem  = '0;
    d_d.root = '0;
    if (d_d.lin) begin
      d_d.ok   = s_q.it.bv != '0;
      d_d.disc = '0;
    end else if (s_q.it.qa[QaW-1]) begin
      d_d.ok   = 1'b1;
      d_d.disc = DiscW'(s_q.bv2) + DiscW'(s_q.qbb);
    end else if (s_q.qbb <= s_q.bv2) begin
      d_d.ok   = 1'b1;
      d_d.disc = DiscW'(s_q.bv2 - s_q.qbb);
    end else begin
      d_d.ok   = 1'b0;
      d_d.disc = '0;
    end
  end

  // stable root pair set-up for both dividers
  sq_t                sq_last;
  logic signed [57:0] rs, bvx, tmp;
  logic [RemW-1:0]    tmpm, qam58, den2;
  logic [54:0]        bvm55;
  always_comb begin
    sq_last = sq_q[SqSteps-1];
    rs      = $signed({2'b00, sq_last.root});
    bvx     = 58'(sq_last.it.bv);
    tmp     = sq_last.it.bv[BvW-1] ? rs - bvx : -(bvx + rs);
    tmpm    = tmp[57] ? 58'(-tmp) : tmp;
    qam58   = sq_last.it.qa[QaW-1] ? 58'(-sq_last.it.qa) : 58'(sq_last.it.qa);
    bvm55   = sq_last.it.bv[BvW-1] ? 55'(-sq_last.it.bv) : sq_last.it.bv;
    den2    = {2'b00, bvm55, 1'b0};
    t_d.it  = sq_last.it;
    t_d.lin = sq_last.lin;
    t_d.ok  = sq_last.ok && (sq_last.lin || tmp != '0);
    if (sq_last.lin) begin
      t_d.la = tdv_init(sq_last.it.bb, den2,
                        (sq_last.it.bb != '0) != sq_last.it.bv[BvW-1]);
    end else begin
      t_d.la = tdv_init(tmpm, qam58, tmp[57] != sq_last.it.qa[QaW-1]);
    end
    t_d.lb = tdv_init(sq_last.it.bb, tmpm, tmp[57]);
  end

  // pick the earliest positive root
  dv_t                dv_last;
  logic signed [41:0] t1, t2, tsel;
  always_comb begin
    dv_last = dv_q[DivSteps-1];
    t1      = tclamp(dv_last.la);
    t2      = tclamp(dv_last.lb);
    if (dv_last.lin)     tsel = t1;
    else if (t1[41])     tsel = t2;
    else if (t2[41])     tsel = t1;
    else if (t1 < t2)    tsel = t1;
    else                 tsel = t2;
    sel_d.it = dv_last.it;
    sel_d.ok = dv_last.ok && !tsel[41] && tsel != '0;
    sel_d.t  = tsel[40:0];
  end

  // aim division set-up: big marks a quotient of 2^26 or more
  logic [BW-1:0] bmag [3];
  logic [44:0]   an   [3];
  always_comb begin
    as_d.it = sel_q.it;
    as_d.ok = sel_q.ok;
    as_d.t  = sel_q.t;
    for (int k = 0; k < 3; k++) begin
      bmag[k]        = sel_q.it.b[k][BW-1] ? BW'(-$signed(sel_q.it.b[k])) : sel_q.it.b[k];
      an[k]          = {bmag[k], 16'h0000};
      as_d.ln[k].big = 41'(an[k][44:26]) >= sel_q.t;
      as_d.ln[k].rem = as_d.ln[k].big ? '0 : 41'(an[k][44:26]);
      as_d.ln[k].n   = an[k][25:0];
      as_d.ln[k].q   = '0;
      as_d.ln[k].neg = sel_q.it.b[k][BW-1];
    end
  end

  // add the target velocity, clamp and pack
  am_t                am_last;
  logic signed [27:0] qs   [3];
  logic signed [27:0] asum [3];
  logic signed [27:0] aim  [3];
  logic [31:0]        ht;
  logic               sat;
  always_comb begin
    am_last = am_q[AimSteps-1];
    sat     = 1'b0;
    for (int k = 0; k < 3; k++) begin
      qs[k]   = am_last.ln[k].neg ? -$signed({2'b00, am_last.ln[k].q})
                                  : $signed({2'b00, am_last.ln[k].q});
      asum[k] = qs[k] + 28'($signed(am_last.it.v[k]));
      if (am_last.ln[k].big) begin
        aim[k] = am_last.ln[k].neg ? AimMin : AimMax;
        sat    = 1'b1;
      end else if (asum[k] > AimMax) begin
        aim[k] = AimMax;
        sat    = 1'b1;
      end else if (asum[k] < AimMin) begin
        aim[k] = AimMin;
        sat    = 1'b1;
      end else begin
        aim[k] = asum[k];
      end
    end
    if (am_last.t > TimeMax) begin
      ht  = TimeMax[31:0];
      sat = 1'b1;
    end else begin
      ht  = am_last.t[31:0];
    end
    if (am_last.ok) begin
      out_data_d = {5'b0, ht, aim[2][VW-1:0], aim[1][VW-1:0], aim[0][VW-1:0]};
      out_user_d = {sat, 1'b1};
    end else begin
      out_data_d = {5'b0, NoTime, 75'b0};
      out_user_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      s_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      sq_valid_q  <= '0;
      t_valid_q   <= 1'b0;
      dv_valid_q  <= '0;
      sel_valid_q <= 1'b0;
      as_valid_q  <= 1'b0;
      am_valid_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      p_valid_q   <= in_valid_i;
      s_valid_q   <= p_valid_q;
      d_valid_q   <= s_valid_q;
      sq_valid_q  <= {sq_valid_q[SqSteps-2:0], d_valid_q};
      t_valid_q   <= sq_valid_q[SqSteps-1];
      dv_valid_q  <= {dv_valid_q[DivSteps-2:0], t_valid_q};
      sel_valid_q <= dv_valid_q[DivSteps-1];
      as_valid_q  <= sel_valid_q;
      am_valid_q  <= {am_valid_q[AimSteps-2:0], as_valid_q};
      out_valid_q <= am_valid_q[AimSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q     <= p_d;
      s_q     <= s_d;
      d_q     <= d_d;
      sq_q[0] <= sq_step(d_q);
      for (int k = 1; k < SqSteps; k++) sq_q[k] <= sq_step(sq_q[k-1]);
      t_q     <= t_d;
      dv_q[0] <= dv_step(t_q);
      for (int k = 1; k < DivSteps; k++) dv_q[k] <= dv_step(dv_q[k-1]);
      sel_q   <= sel_d;
      as_q    <= as_d;
      am_q[0] <= am_step(as_q);
      for (int k = 1; k < AimSteps; k++) am_q[k] <= am_step(am_q[k-1]);
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

endmodule
`default_nettype wire
